@@ rtl/cct_pkg.sv @@
`timescale 1ns / 1ps

package cct_pkg;

    // Fixed sizes of the block.
    localparam int CLASS_ENTRIES      = 256;
    localparam int MAX_BUFFER_DEFAULT = 65536;
    localparam int QUEUE_DEPTH        = 4;

    // Field widths of the result item.
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    // Input commands.
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STRING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd2;

    // Bit positions within a class entry.
    localparam int CLS_WORD  = 0;
    localparam int CLS_SPACE = 1;
    localparam int CLS_QUOTE = 2;

    localparam logic [7:0] BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  ch;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } token_t;

    // Up to two tokens handed from the lexer to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_push_t;

    typedef struct packed {
        logic [$clog2(QUEUE_DEPTH+1)-1:0] fill;
        logic                             room;
    } queue_status_t;

    // Class of a byte before any table write: letters, digits and underscore
    // are word characters, control bytes up to the blank are space, and the
    // two quote marks open strings.
    function automatic logic [2:0] default_class(input logic [7:0] b);
        logic [2:0] c;
        c = 3'd0;
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h30 && b <= 8'h39) || b == 8'h5F)
        begin
            c[CLS_WORD] = 1'b1;
        end
        if (b >= 8'h01 && b <= 8'h20)
        begin
            c[CLS_SPACE] = 1'b1;
        end
        if (b == 8'h27 || b == 8'h22)
        begin
            c[CLS_QUOTE] = 1'b1;
        end
        return c;
    endfunction

endpackage

@@ rtl/cct_channels.sv @@
`timescale 1ns / 1ps

// Byte stream channel: one item is a command with its byte and class bits.
interface cct_stream_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [2:0] class_bits;

    modport source (output valid, output command, output data_byte, output class_bits,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input class_bits,
                    output ready);
endinterface

// Token channel: one item is one token.
interface cct_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [7:0]  token_char;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic        last_result;

    modport source (output valid, output token_kind, output token_char,
                    output token_start, output token_length, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input token_char,
                    input token_start, input token_length, input last_result,
                    output ready);
endinterface

@@ rtl/cct_class_table.sv @@
`timescale 1ns / 1ps

module cct_class_table (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  logic       wr_en,
    input  logic [7:0] addr,
    input  logic [2:0] wr_class,
    output logic [2:0] rd_class
);
    import cct_pkg::*;

    logic [2:0]               mem [CLASS_ENTRIES];
    logic [CLASS_ENTRIES-1:0] written_reg;
    logic [2:0]               rd_data_reg;
    logic                     rd_written_reg;
    logic [7:0]               rd_addr_reg;

    // Table storage, no reset: entries not yet written read as the default.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_class;
        end
    end

    // One flag per entry marks it as written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[addr] <= 1'b1;
        end
    end

    // Registered read, taken when the item is accepted.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg    <= mem[addr];
            rd_written_reg <= written_reg[addr];
            rd_addr_reg    <= addr;
        end
    end

    assign rd_class = rd_written_reg ? rd_data_reg : default_class(rd_addr_reg);

endmodule

@@ rtl/cct_lexer.sv @@
`timescale 1ns / 1ps

module cct_lexer #(
    parameter int MAX_BUFFER = cct_pkg::MAX_BUFFER_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           command,
    input  logic [7:0]           data_byte,
    input  logic [2:0]           cls,
    input  logic                 room,
    output logic                 ready,
    output cct_pkg::token_push_t push
);
    import cct_pkg::*;

    localparam int POS_W  = $clog2(MAX_BUFFER + 1);
    localparam int BEG_W  = $clog2(MAX_BUFFER);
    localparam int WIDE_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic             stage_valid_reg;
    logic [1:0]       stage_cmd_reg;
    logic [7:0]       stage_byte_reg;

    logic             in_word_reg, in_word_next;
    logic             in_space_reg, in_space_next;
    logic [7:0]       open_quote_reg, open_quote_next;
    logic             in_escape_reg, in_escape_next;
    logic [BEG_W-1:0] begin_reg, begin_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             advance;
    token_push_t      push_comb;

    // Builds a token, fitting offset and length to the port widths.
    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [BEG_W-1:0]  start,
                                          input logic [POS_W-1:0]  length);
        token_t           t;
        logic [WIDE_W-1:0] s_wide;
        logic [WIDE_W-1:0] l_wide;
        s_wide   = WIDE_W'(start);
        l_wide   = WIDE_W'(length);
        t.kind   = kind;
        t.ch     = ch;
        t.start  = s_wide[START_W-1:0];
        t.length = l_wide[LEN_W-1:0];
        t.last   = 1'b0;
        return t;
    endfunction

    assign advance = stage_valid_reg && room;
    assign ready   = !stage_valid_reg || room;

    // Input stage: holds the item while its class entry is read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg  <= command;
            stage_byte_reg <= data_byte;
        end
    end

    // Run state update and token generation for the staged item.
    always_comb
    begin
        logic [BEG_W-1:0] p;
        logic [1:0]       cnt;
        token_t           t0;
        token_t           t1;
        logic             w;

        p = (pos_reg < POS_W'(MAX_BUFFER)) ? pos_reg[BEG_W-1:0] : BEG_W'(MAX_BUFFER - 1);
        cnt = 2'd0;
        t0  = '0;
        t1  = '0;
        w   = in_word_reg;

        in_word_next    = in_word_reg;
        in_space_next   = in_space_reg;
        open_quote_next = open_quote_reg;
        in_escape_next  = in_escape_reg;
        begin_next      = begin_reg;
        pos_next        = pos_reg;

        if (stage_cmd_reg == CMD_END)
        begin
            // End of buffer: flush a pending word, restart the offsets.
            if (in_word_reg)
            begin
                t0  = make_token(KIND_WORD, '0, begin_reg, pos_reg - POS_W'(begin_reg));
                cnt = 2'd1;
            end
            in_word_next    = 1'b0;
            in_space_next   = 1'b0;
            open_quote_next = 8'd0;
            in_escape_next  = 1'b0;
            pos_next        = '0;
        end
        else if (stage_cmd_reg == CMD_DATA)
        begin
            if (stage_byte_reg == 8'd0)
            begin
                // A zero byte ends the data: flush the word, clear all runs.
                if (in_word_reg)
                begin
                    t0  = make_token(KIND_WORD, '0, begin_reg, POS_W'(p - begin_reg));
                    cnt = 2'd1;
                end
                in_word_next    = 1'b0;
                in_space_next   = 1'b0;
                open_quote_next = 8'd0;
                in_escape_next  = 1'b0;
            end
            else if (in_escape_reg)
            begin
                in_escape_next = 1'b0;
            end
            else if (open_quote_reg != 8'd0 && stage_byte_reg == BACKSLASH)
            begin
                in_escape_next = 1'b1;
            end
            else if (open_quote_reg != 8'd0 && stage_byte_reg == open_quote_reg)
            begin
                // Closing quote: the string includes both quote marks.
                t0  = make_token(KIND_STRING, '0, begin_reg,
                                 POS_W'(p - begin_reg) + POS_W'(1));
                cnt = 2'd1;
                open_quote_next = 8'd0;
            end
            else
            begin
                if (in_word_reg && !cls[CLS_WORD])
                begin
                    t0  = make_token(KIND_WORD, '0, begin_reg, POS_W'(p - begin_reg));
                    cnt = 2'd1;
                    w   = 1'b0;
                end
                in_word_next = w;
                if (in_space_reg && !cls[CLS_SPACE])
                begin
                    in_space_next = 1'b0;
                end
                if (!w && !in_space_next && open_quote_reg == 8'd0)
                begin
                    if (cls[CLS_WORD])
                    begin
                        in_word_next = 1'b1;
                        begin_next   = p;
                    end
                    else if (cls[CLS_SPACE])
                    begin
                        in_space_next = 1'b1;
                    end
                    else if (cls[CLS_QUOTE])
                    begin
                        open_quote_next = stage_byte_reg;
                        begin_next      = p;
                    end
                    else if (cnt == 2'd0)
                    begin
                        t0  = make_token(KIND_CHAR, stage_byte_reg, p, POS_W'(1));
                        cnt = 2'd1;
                    end
                    else
                    begin
                        t1  = make_token(KIND_CHAR, stage_byte_reg, p, POS_W'(1));
                        cnt = 2'd2;
                    end
                end
            end
            if (pos_reg < POS_W'(MAX_BUFFER))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        t0.last = (cnt == 2'd1);
        t1.last = 1'b1;

        push_comb.count  = advance ? cnt : 2'd0;
        push_comb.first  = t0;
        push_comb.second = t1;
    end

    assign push = push_comb;

    // Run state registers, updated as the staged item moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg    <= 1'b0;
            in_space_reg   <= 1'b0;
            open_quote_reg <= 8'd0;
            in_escape_reg  <= 1'b0;
            begin_reg      <= '0;
            pos_reg        <= '0;
        end
        else if (advance)
        begin
            in_word_reg    <= in_word_next;
            in_space_reg   <= in_space_next;
            open_quote_reg <= open_quote_next;
            in_escape_reg  <= in_escape_next;
            begin_reg      <= begin_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

@@ rtl/cct_result_queue.sv @@
`timescale 1ns / 1ps

module cct_result_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cct_pkg::token_push_t   push,
    input  logic                   pop,
    output logic                   out_valid,
    output cct_pkg::token_t        head,
    output cct_pkg::queue_status_t status
);
    import cct_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    token_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [PTR_W-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Token storage: up to two tokens are written per cycle.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + FILL_W'(push.count) - FILL_W'(pop);
        end
    end

    assign out_valid   = (fill_reg != '0);
    assign head        = entry_reg[rd_ptr_reg];
    assign status.fill = fill_reg;
    assign status.room = (fill_reg <= FILL_W'(QUEUE_DEPTH - 2));

endmodule

@@ rtl/char_class_tokenizer_top.sv @@
`timescale 1ns / 1ps

// Character class tokenizer. Items: a data byte, an end of buffer mark, or a write into
// the 256-entry class table. It returns word, quoted string and single character tokens
// with their start offset and length on the tokens channel, up to two per item, the last
// one flagged by last_result. An item waits in the input stage while its class entry is
// read from the table's registered port, then pushes its tokens into the result queue;
// the sustained rate is one item per clock while items yield at most one token each and
// the receiver keeps up. The result queue holds four tokens and drains one per clock while
// the receiver is ready, so items that yield two tokens in a row slow the input to the
// pace of the output. The class table comes out of reset with its default classes at once:
// a written flag per entry selects between the stored class and the default.
module char_class_tokenizer_top #(
    parameter int MAX_BUFFER = cct_pkg::MAX_BUFFER_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    cct_stream_if.sink  stream,
    cct_token_if.source tokens
);
    import cct_pkg::*;

    logic          accept;
    logic [2:0]    cls;
    logic          lexer_ready;
    token_push_t   push;
    token_t        head;
    queue_status_t status;
    logic          out_valid;
    logic          pop;

    assign accept       = stream.valid && stream.ready;
    assign stream.ready = lexer_ready;

    cct_class_table u_class_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .wr_en    (accept && stream.command == CMD_WRITE),
        .addr     (stream.data_byte),
        .wr_class (stream.class_bits),
        .rd_class (cls)
    );

    cct_lexer #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (stream.command),
        .data_byte (stream.data_byte),
        .cls       (cls),
        .room      (status.room),
        .ready     (lexer_ready),
        .push      (push)
    );

    cct_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .out_valid (out_valid),
        .head      (head),
        .status    (status)
    );

    // Result channel.
    assign pop                 = out_valid && tokens.ready;
    assign tokens.valid        = out_valid;
    assign tokens.token_kind   = head.kind;
    assign tokens.token_char   = head.ch;
    assign tokens.token_start  = head.start;
    assign tokens.token_length = head.length;
    assign tokens.last_result  = head.last;

    // The queue is never written beyond its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |->
            (4'(status.fill) + 4'(push.count)) <= 4'(QUEUE_DEPTH))
    else $error("result queue overflow");

    // A single character token is one nonzero byte long; other tokens carry no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid |->
            (tokens.token_kind == KIND_CHAR) ?
                (tokens.token_length == 17'd1 && tokens.token_char != 8'd0) :
                (tokens.token_char == 8'd0))
    else $error("malformed token");

    // The second token of an item is ready right after the first one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.ready && !tokens.last_result) |=> tokens.valid)
    else $error("second token of an item missing");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

import cct_pkg::*;

// Command code that the block accepts and then ignores.
localparam logic [1:0] CMD_UNUSED = 2'd3;

// Tracks the class table and run state of the lexer and holds the tokens still owed.
class token_checker;
    logic [2:0]  class_mem [CLASS_ENTRIES];
    logic        word_run;
    logic        space_run;
    logic        escape_next;
    logic [7:0]  quote_char;
    logic [15:0] begin_at;
    int          position;
    token_t      pending [$];
    int          errors;

    function new();
        for (int i = 0; i < CLASS_ENTRIES; i++)
        begin
            class_mem[i] = base_class(8'(i));
        end
        clear_run();
        begin_at = '0;
        position = 0;
        errors   = 0;
    endfunction

    // Class of a byte straight out of reset.
    function logic [2:0] base_class(input logic [7:0] b);
        logic [2:0] c;
        c = 3'd0;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
            b == "_")
        begin
            c[CLS_WORD] = 1'b1;
        end
        if (b >= 8'd1 && b <= " ")
        begin
            c[CLS_SPACE] = 1'b1;
        end
        if (b == "'" || b == "\"")
        begin
            c[CLS_QUOTE] = 1'b1;
        end
        return c;
    endfunction

    function void clear_run();
        word_run    = 1'b0;
        space_run   = 1'b0;
        escape_next = 1'b0;
        quote_char  = 8'd0;
    endfunction

    function token_t make_token(input logic [KIND_W-1:0] kind, input logic [7:0] ch,
                                input int start, input int len);
        token_t t;
        t.kind   = kind;
        t.ch     = ch;
        t.start  = start[START_W-1:0];
        t.length = len[LEN_W-1:0];
        t.last   = 1'b0;
        return t;
    endfunction

    // Works out the tokens that one accepted input item gives rise to.
    function void note_item(input logic [1:0] cmd, input logic [7:0] b,
                            input logic [2:0] cls_in);
        token_t     found [$];
        int         p;
        logic [2:0] cls;
        if (cmd == CMD_WRITE)
        begin
            class_mem[b] = cls_in;
            return;
        end
        if (cmd == CMD_UNUSED)
        begin
            return;
        end
        if (cmd == CMD_END)
        begin
            if (word_run)
            begin
                found.push_back(make_token(KIND_WORD, 8'd0, begin_at, position - begin_at));
            end
            clear_run();
            position = 0;
        end
        else
        begin
            p   = (position < MAX_BUFFER_DEFAULT) ? position : MAX_BUFFER_DEFAULT - 1;
            cls = class_mem[b];
            if (b == 8'd0)
            begin
                // A zero byte ends the data: flush the word and drop any open string.
                if (word_run)
                begin
                    found.push_back(make_token(KIND_WORD, 8'd0, begin_at, p - begin_at));
                end
                clear_run();
            end
            else if (escape_next)
            begin
                escape_next = 1'b0;
            end
            else if (quote_char != 8'd0 && b == BACKSLASH)
            begin
                escape_next = 1'b1;
            end
            else if (quote_char != 8'd0 && b == quote_char)
            begin
                found.push_back(make_token(KIND_STRING, 8'd0, begin_at, p - begin_at + 1));
                quote_char = 8'd0;
            end
            else
            begin
                if (word_run && !cls[CLS_WORD])
                begin
                    found.push_back(make_token(KIND_WORD, 8'd0, begin_at, p - begin_at));
                    word_run = 1'b0;
                end
                if (space_run && !cls[CLS_SPACE])
                begin
                    space_run = 1'b0;
                end
                if (!word_run && !space_run && quote_char == 8'd0)
                begin
                    // Word wins over space, and space over quote.
                    if (cls[CLS_WORD])
                    begin
                        word_run = 1'b1;
                        begin_at = p[15:0];
                    end
                    else if (cls[CLS_SPACE])
                    begin
                        space_run = 1'b1;
                    end
                    else if (cls[CLS_QUOTE])
                    begin
                        quote_char = b;
                        begin_at   = p[15:0];
                    end
                    else
                    begin
                        found.push_back(make_token(KIND_CHAR, b, p, 1));
                    end
                end
            end
            if (position < MAX_BUFFER_DEFAULT)
            begin
                position++;
            end
        end
        if (found.size() > 0)
        begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i])
        begin
            pending.push_back(found[i]);
        end
    endfunction

    // Compares one accepted token with the oldest one owed.
    function void check_token(input token_t got);
        token_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("unexpected token: kind %0d char %02h start %0d length %0d last %0b",
                         got.kind, got.ch, got.start, got.length, got.last);
            end
            return;
        end
        want = pending.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.start !== want.start ||
            got.length !== want.length || got.last !== want.last)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("token mismatch: expected kind %0d char %02h start %0d length %0d last %0b",
                         want.kind, want.ch, want.start, want.length, want.last);
                $display("                got      kind %0d char %02h start %0d length %0d last %0b",
                         got.kind, got.ch, got.start, got.length, got.last);
            end
        end
    endfunction
endclass

module testbench;
    logic         clk;
    logic         rst_n;
    int           send_idle;
    int           recv_idle;
    int           items_sent;
    token_checker sb;

    cct_stream_if stream_ch ();
    cct_token_if  token_ch ();

    char_class_tokenizer_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .tokens (token_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the length of the run.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // The token receiver stalls at random.
    always @(posedge clk)
    begin
        token_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Note each accepted input item, then check each accepted token.
    always @(posedge clk)
    begin
        token_t got;
        if (rst_n)
        begin
            if (stream_ch.valid && stream_ch.ready)
            begin
                sb.note_item(stream_ch.command, stream_ch.data_byte, stream_ch.class_bits);
            end
            if (token_ch.valid && token_ch.ready)
            begin
                got.kind   = token_ch.token_kind;
                got.ch     = token_ch.token_char;
                got.start  = token_ch.token_start;
                got.length = token_ch.token_length;
                got.last   = token_ch.last_result;
                sb.check_token(got);
            end
        end
    end

    // Offers one item, with random gaps in front, and waits until it is taken.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [2:0] cls);
        while ($urandom_range(99) < send_idle)
        begin
            stream_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stream_ch.valid      <= 1'b1;
        stream_ch.command    <= cmd;
        stream_ch.data_byte  <= b;
        stream_ch.class_bits <= cls;
        @(posedge clk);
        while (!stream_ch.ready)
        begin
            @(posedge clk);
        end
        if (cmd != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Holds the sender back until every owed token has come out.
    task automatic wait_drained();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Puts back the reset class of every entry that a write has changed.
    task automatic restore_classes();
        for (int i = 0; i < CLASS_ENTRIES; i++)
        begin
            if (sb.class_mem[i] !== sb.base_class(8'(i)))
            begin
                send_item(CMD_WRITE, 8'(i), sb.base_class(8'(i)));
            end
        end
    endtask

    // One piece of text: mostly well formed words, blanks and strings, some noise.
    task automatic emit_fragment();
        int         pick;
        int         len;
        int         idx;
        logic [7:0] q;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                idx = $urandom_range(0, 62);
                if (idx < 26)
                begin
                    b = 8'("a" + idx);
                end
                else if (idx < 52)
                begin
                    b = 8'("A" + idx - 26);
                end
                else if (idx < 62)
                begin
                    b = 8'("0" + idx - 52);
                end
                else
                begin
                    b = "_";
                end
                send_item(CMD_DATA, b, 3'($urandom_range(7)));
            end
        end
        else if (pick < 50)
        begin
            len = $urandom_range(1, 3);
            repeat (len)
            begin
                send_item(CMD_DATA, 8'($urandom_range(1, 32)), 3'($urandom_range(7)));
            end
        end
        else if (pick < 65)
        begin
            // Quoted string with random content and escapes; now and then left open.
            q = $urandom_range(1) ? 8'h22 : 8'h27;
            send_item(CMD_DATA, q, 3'($urandom_range(7)));
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                if ($urandom_range(99) < 20)
                begin
                    send_item(CMD_DATA, BACKSLASH, 3'($urandom_range(7)));
                    send_item(CMD_DATA, 8'($urandom_range(1, 255)), 3'($urandom_range(7)));
                end
                else
                begin
                    b = 8'($urandom_range(1, 255));
                    if (b == q || b == BACKSLASH)
                    begin
                        b = "a";
                    end
                    send_item(CMD_DATA, b, 3'($urandom_range(7)));
                end
            end
            if ($urandom_range(99) < 90)
            begin
                send_item(CMD_DATA, q, 3'($urandom_range(7)));
            end
        end
        else if (pick < 80)
        begin
            do
            begin
                b = 8'($urandom_range(33, 255));
            end
            while (sb.base_class(b) != 3'd0);
            send_item(CMD_DATA, b, 3'($urandom_range(7)));
        end
        else if (pick < 85)
        begin
            send_item(CMD_DATA, 8'($urandom_range(255)), 3'($urandom_range(7)));
        end
        else if (pick < 90)
        begin
            send_item(CMD_END, 8'($urandom_range(255)), 3'($urandom_range(7)));
        end
        else if (pick < 94)
        begin
            idx = $urandom_range(1) ? $urandom_range(255) : $urandom_range(128, 255);
            send_item(CMD_WRITE, 8'(idx), 3'($urandom_range(7)));
        end
        else if (pick < 97)
        begin
            send_item(CMD_DATA, 8'd0, 3'($urandom_range(7)));
        end
        else
        begin
            send_item(CMD_UNUSED, 8'($urandom_range(255)), 3'($urandom_range(7)));
        end
    endtask

    // One phase of random text under the given stall rates.
    task automatic run_phase(input int sender_pct, input int receiver_pct, input int target);
        send_idle = sender_pct;
        recv_idle = receiver_pct;
        restore_classes();
        while (items_sent < target)
        begin
            emit_fragment();
        end
        wait_drained();
    endtask

    initial
    begin
        sb                   = new();
        rst_n                = 1'b0;
        stream_ch.valid      = 1'b0;
        stream_ch.command    = CMD_DATA;
        stream_ch.data_byte  = 8'd0;
        stream_ch.class_bits = 3'd0;
        token_ch.ready       = 1'b0;
        send_idle            = 0;
        recv_idle            = 0;
        items_sent           = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the first stall rates.
        send_idle = 24;
        recv_idle = 46;
        // A word ended by a single character: two tokens from one item.
        send_item(CMD_DATA, "a", 3'd0);
        send_item(CMD_DATA, "9", 3'd7);
        send_item(CMD_DATA, "+", 3'd0);
        send_item(CMD_DATA, " ", 3'd0);
        send_item(CMD_DATA, 8'h09, 3'd0);
        // String whose first closing quote is escaped.
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, "x", 3'd0);
        send_item(CMD_DATA, BACKSLASH, 3'd0);
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, "y", 3'd0);
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, 8'hFF, 3'd0);
        // All class bits set: the word bit wins.
        send_item(CMD_WRITE, 8'hFF, 3'd7);
        send_item(CMD_DATA, 8'hFF, 3'd0);
        send_item(CMD_DATA, 8'hFF, 3'd0);
        send_item(CMD_END, 8'h00, 3'd0);
        send_item(CMD_UNUSED, 8'hFF, 3'd7);
        // A zero byte inside a string, just after a backslash.
        send_item(CMD_DATA, "'", 3'd0);
        send_item(CMD_DATA, BACKSLASH, 3'd0);
        send_item(CMD_DATA, 8'h00, 3'd0);
        send_item(CMD_DATA, "z", 3'd0);
        send_item(CMD_DATA, 8'h00, 3'd0);
        // String left open at the end of the buffer.
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, "k", 3'd0);
        send_item(CMD_END, 8'hFF, 3'd7);
        send_item(CMD_WRITE, 8'hFF, 3'd0);
        wait_drained();

        run_phase(24, 46, 300);
        run_phase(46, 24, 600);
        run_phase(0, 0, 900);

        // A short closing buffer: a word, a character, a string and a word flushed by the end.
        send_item(CMD_DATA, "x", 3'd0);
        send_item(CMD_DATA, "y", 3'd0);
        send_item(CMD_DATA, "+", 3'd0);
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, "q", 3'd0);
        send_item(CMD_DATA, "\"", 3'd0);
        send_item(CMD_DATA, "b", 3'd0);
        send_item(CMD_END, 8'h00, 3'd0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
